>>> rtl/core/tccl_pkg.sv
// Shared types and constants for the two-character name code lookup.
// Holds the controller state, the command and status structs and the field codes.
// No dependencies.
`timescale 1ns / 1ps

package tccl_pkg;

  // Input field codes.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;
  localparam logic SEL_NORMAL  = 1'b0;
  localparam logic SEL_SPECIAL = 1'b1;

  // A single-character name maps to its first byte with the top bit dropped.
  localparam logic [7:0] SINGLE_MASK = 8'h7F;

  // Register index, taken from bit 2 of the byte address.
  localparam logic REG_NORMAL_COUNT  = 1'b0;
  localparam logic REG_SPECIAL_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_RD_FIRST,
    ST_CHK_FIRST,
    ST_PROBE,
    ST_FINAL,
    ST_DONE
  } tccl_state_e;

  typedef enum logic [1:0] {
    RADDR_LAST,
    RADDR_FIRST,
    RADDR_MID
  } tccl_raddr_e;

  typedef enum logic [1:0] {
    RES_SINGLE,
    RES_ZERO,
    RES_MATCH
  } tccl_res_e;

  typedef struct packed {
    logic        accept;     // capture a lookup item
    logic        mem_we;     // write a load item into the table
    tccl_raddr_e raddr_sel;  // which table position to read
    logic        chk_last;   // compare against the last entry
    logic        chk_first;  // take the first entry as the lower bound
    logic        probe;      // one halving step
    logic        res_load;
    tccl_res_e   res_sel;
    logic        out_load;   // move the result into the output register
  } tccl_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_single;
    logic cnt_zero;
    logic outside;
    logic one_entry;
    logic probe_end;
  } tccl_sts_t;

endpackage

>>> rtl/core/two_char_name_code_lookup.sv
// Top level of the two-character name code lookup: register port, controller, datapath.
// Depends on tccl_pkg, tccl_ctrl and tccl_dpath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  action, table_select, key, entry_index/code
// out       output     out_valid_o/out_stall_i code
// config    input      psel/penable/pwrite    normal_count at 0x0, special_count at 0x4
//
// A load item writes one entry of the selected table when it is taken.
// A single-character lookup on the normal table, or a lookup on an empty table, reads no table
// entry; its result goes from the result register into the output register.
// A search reads the last and the first entry, then does one halving probe per cycle through
// the single read port of the table memory.
// The input is stalled from the cycle after a lookup is taken until its result has entered the
// output register; a result waiting there does not hold back the next item.
// Reset clears both counts and the control state; the table contents are undefined until loaded.

module two_char_name_code_lookup import tccl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic        table_select_i,
  input  logic [7:0]  key_first_i,
  input  logic [7:0]  key_second_i,
  input  logic [6:0]  entry_index_i,
  input  logic [7:0]  entry_code_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  code_o,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tccl_cmd_t  cmd;
  tccl_sts_t  sts;
  logic [7:0] normal_count_q;
  logic [7:0] special_count_q;
  logic       cfg_wr;

  // The port never waits; bit 2 of the byte address picks the register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_count_q  <= 8'h00;
      special_count_q <= 8'h00;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_NORMAL_COUNT) begin
        normal_count_q <= pwdata[7:0];
      end else begin
        special_count_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SPECIAL_COUNT) ? {24'h0, special_count_q}
                                                  : {24'h0, normal_count_q};

  // The controller steps each item through the search; the datapath owns the tables.
  tccl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tccl_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (action_i),
    .table_select_i  (table_select_i),
    .key_first_i     (key_first_i),
    .key_second_i    (key_second_i),
    .entry_index_i   (entry_index_i),
    .entry_code_i    (entry_code_i),
    .normal_count_i  (normal_count_q),
    .special_count_i (special_count_q),
    .code_o          (code_o)
  );

  // A load item never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && action_i == ACT_LOAD && !out_valid_o) |=> !out_valid_o)
    else $error("load item produced a result");

  // A single-character name on the normal table returns its masked first byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && action_i == ACT_LOOKUP && table_select_i == SEL_NORMAL &&
     key_second_i == 8'h00 && !out_valid_o)
    |=> ##1 (out_valid_o && code_o == $past(key_first_i & SINGLE_MASK, 2)))
    else $error("single-character lookup gave a wrong result");

  // A lookup on an empty special table returns zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && action_i == ACT_LOOKUP && table_select_i == SEL_SPECIAL &&
     special_count_q == 8'h00 && !out_valid_o)
    |=> ##1 (out_valid_o && code_o == 8'h00))
    else $error("empty table lookup did not return zero");

endmodule

>>> rtl/core/tccl_ctrl.sv
// Controller of the name code lookup: sequences one item through the search.
// Depends on tccl_pkg for the state enum and the command and status structs.
`timescale 1ns / 1ps

module tccl_ctrl import tccl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  tccl_sts_t sts_i,
  output tccl_cmd_t cmd_o
);

  tccl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The output register can take a new result once its item has gone.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !sts_i.is_load) begin
          if (sts_i.is_single || sts_i.cnt_zero) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_RD_LAST;
          end
        end
      end
      ST_RD_LAST:  state_d = ST_RD_FIRST;
      ST_RD_FIRST: state_d = ST_CHK_FIRST;
      ST_CHK_FIRST: begin
        if (sts_i.outside) begin
          state_d = ST_DONE;
        end else if (sts_i.one_entry) begin
          state_d = ST_FINAL;
        end else begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (sts_i.probe_end) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.raddr_sel = RADDR_LAST;
    cmd_o.res_sel   = RES_ZERO;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.is_load) begin
            cmd_o.mem_we = 1'b1;
          end else begin
            cmd_o.accept = 1'b1;
            if (sts_i.is_single) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_SINGLE;
            end else if (sts_i.cnt_zero) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_ZERO;
            end
          end
        end
      end
      ST_RD_LAST: cmd_o.raddr_sel = RADDR_LAST;
      ST_RD_FIRST: begin
        cmd_o.raddr_sel = RADDR_FIRST;
        cmd_o.chk_last  = 1'b1;
      end
      ST_CHK_FIRST: begin
        cmd_o.chk_first = 1'b1;
        if (sts_i.outside) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_ZERO;
        end else if (!sts_i.one_entry) begin
          cmd_o.raddr_sel = RADDR_MID;
        end
      end
      ST_PROBE: begin
        cmd_o.probe     = 1'b1;
        cmd_o.raddr_sel = RADDR_MID;
      end
      ST_FINAL: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_MATCH;
      end
      ST_DONE: cmd_o.out_load = out_free;
      default: cmd_o.out_load = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/tccl_dpath.sv
// Datapath of the name code lookup: table memory, search bounds and result registers.
// Depends on tccl_pkg for the command and status structs and the field codes.
`timescale 1ns / 1ps

module tccl_dpath import tccl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic       clk_i,
  input  tccl_cmd_t  cmd_i,
  output tccl_sts_t  sts_o,
  input  logic       action_i,
  input  logic       table_select_i,
  input  logic [7:0] key_first_i,
  input  logic [7:0] key_second_i,
  input  logic [6:0] entry_index_i,
  input  logic [7:0] entry_code_i,
  input  logic [7:0] normal_count_i,
  input  logic [7:0] special_count_i,
  output logic [7:0] code_o
);

  localparam int unsigned AW        = $clog2(TABLE_DEPTH);
  localparam int unsigned CW        = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW        = CW + 1;
  localparam int unsigned MEM_DEPTH = 2 ** (AW + 1);
  localparam logic [8:0]  DEPTH9    = 9'(TABLE_DEPTH);

  // A count above the table depth searches the whole table.
  function automatic logic [CW-1:0] clamp_count(logic [7:0] cnt);
    logic [8:0] cnt9;
    cnt9 = {1'b0, cnt};
    return (cnt9 > DEPTH9) ? CW'(DEPTH9) : CW'(cnt9);
  endfunction

  logic [23:0]   mem [MEM_DEPTH];
  logic [23:0]   rdata_q;
  logic [15:0]   rd_key;

  logic [15:0]   key_q;
  logic          sel_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] lo_q;
  logic [CW-1:0] hi_q;
  logic [AW-1:0] mid_q;
  logic          above_q;
  logic [23:0]   lo_entry_q;
  logic [7:0]    res_q, res_d;
  logic [7:0]    out_code_q;

  logic [CW-1:0] cnt_sel;
  logic [8:0]    idx9;
  logic          mem_we;
  logic [AW:0]   waddr;
  logic [AW-1:0] raddr_lo;
  logic [AW:0]   raddr;
  logic [CW-1:0] last_idx;
  logic          lt;
  logic [AW-1:0] lo_nx;
  logic [CW-1:0] hi_nx;
  logic [SW-1:0] mid_sum;
  logic [AW-1:0] mid_nx;

  assign cnt_sel = (table_select_i == SEL_SPECIAL) ? clamp_count(special_count_i)
                                                   : clamp_count(normal_count_i);

  // Load items beyond the depth are dropped.
  assign idx9   = {2'b00, entry_index_i};
  assign mem_we = cmd_i.mem_we && (idx9 < DEPTH9);
  assign waddr  = {table_select_i, idx9[AW-1:0]};

  assign rd_key = rdata_q[23:8];
  assign lt     = key_q < rd_key;

  always_comb begin
    lo_nx = lo_q;
    hi_nx = hi_q;
    if (cmd_i.probe) begin
      if (lt) begin
        hi_nx = CW'(mid_q);
      end else begin
        lo_nx = mid_q;
      end
    end
  end

  assign mid_sum  = SW'(lo_nx) + SW'(hi_nx);
  assign mid_nx   = mid_sum[AW:1];
  assign last_idx = cnt_q - CW'(1);

  always_comb begin
    unique case (cmd_i.raddr_sel)
      RADDR_LAST:  raddr_lo = last_idx[AW-1:0];
      RADDR_FIRST: raddr_lo = '0;
      RADDR_MID:   raddr_lo = mid_nx;
      default:     raddr_lo = '0;
    endcase
  end

  assign raddr = {sel_q, raddr_lo};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= {key_first_i, key_second_i, entry_code_i};
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    unique case (cmd_i.res_sel)
      RES_SINGLE: res_d = key_first_i & SINGLE_MASK;
      RES_ZERO:   res_d = 8'h00;
      RES_MATCH:  res_d = (key_q == lo_entry_q[23:8]) ? lo_entry_q[7:0] : 8'h00;
      default:    res_d = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q <= {key_first_i, key_second_i};
      sel_q <= table_select_i;
      cnt_q <= cnt_sel;
      lo_q  <= '0;
      hi_q  <= cnt_sel;
    end else if (cmd_i.probe) begin
      lo_q <= lo_nx;
      hi_q <= hi_nx;
    end
    if (cmd_i.raddr_sel == RADDR_MID) begin
      mid_q <= mid_nx;
    end
    if (cmd_i.chk_last) begin
      above_q <= key_q > rd_key;
    end
    if (cmd_i.chk_first || (cmd_i.probe && !lt)) begin
      lo_entry_q <= rdata_q;
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_code_q <= res_q;
    end
  end

  assign sts_o.is_load   = (action_i == ACT_LOAD);
  assign sts_o.is_single = (table_select_i == SEL_NORMAL) && (key_second_i == 8'h00);
  assign sts_o.cnt_zero  = (cnt_sel == '0);
  assign sts_o.outside   = above_q || lt;
  assign sts_o.one_entry = ((SW'(lo_q) + SW'(1)) == SW'(hi_q));
  assign sts_o.probe_end = ((SW'(lo_nx) + SW'(1)) == SW'(hi_nx));

  assign code_o = out_code_q;

endmodule

>>> tb/sv/two_char_name_code_lookup_tb.sv
// Self-checking testbench for the two-character name code lookup block.
// It loads both tables, sets the counts, fires lookups and checks every code that comes out.
// Depends on tccl_pkg and two_char_name_code_lookup.
`timescale 1ns / 1ps

module two_char_name_code_lookup_tb;
  import tccl_pkg::*;

  localparam int unsigned HALF_PERIOD    = 5;
  localparam int unsigned DEPTH          = 128;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned HOLD_AFTER     = 120;
  localparam int unsigned MAX_REPORTS    = 10;

  // One item of the input channel: either a table load or a lookup.
  typedef struct {
    logic       action;
    logic       sel;
    logic [7:0] key_first;
    logic [7:0] key_second;
    logic [6:0] index;
    logic [7:0] code;
  } table_op_t;

  // A code we are waiting for, with the key that asked for it for the fault report.
  typedef struct {
    logic [7:0]  code;
    logic        sel;
    logic [15:0] key;
  } code_expect_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  // Input channel, driven by the feeder process below.
  logic        in_valid      = 1'b0;
  logic        act_d         = ACT_LOAD;
  logic        sel_d         = SEL_NORMAL;
  logic [7:0]  key_first_d   = 8'h00;
  logic [7:0]  key_second_d  = 8'h00;
  logic [6:0]  index_d       = 7'd0;
  logic [7:0]  code_d        = 8'h00;
  logic        in_stall;

  // Output channel.
  logic        out_stall     = 1'b0;
  logic        out_valid;
  logic [7:0]  code_out;

  // Register port, driven only from the stimulus process.
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = 3'd0;
  logic [31:0] pwdata        = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // Our own copy of the block's state, updated as items are accepted and counts are written.
  logic [15:0] stored_key  [2][DEPTH];
  logic [7:0]  stored_code [2][DEPTH];
  logic [7:0]  table_count [2] = '{8'd0, 8'd0};

  // The keys as the stimulus has issued them, which may run ahead of acceptance.
  logic [15:0] issued_key  [2][DEPTH];

  table_op_t    pending_ops[$];
  table_op_t    cur_op;
  code_expect_t expected_codes[$];

  int unsigned ops_issued     = 0;
  int unsigned ops_accepted   = 0;
  int unsigned loads_seen     = 0;
  int unsigned lookups_seen   = 0;
  int unsigned results_seen   = 0;
  int unsigned codes_checked  = 0;
  int unsigned faults         = 0;
  int unsigned settings_seen  = 0;
  int unsigned stalled_cycles = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_wait      = 0;
  int unsigned recv_wait      = 0;
  bit          held_off       = 1'b0;

  two_char_name_code_lookup u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (act_d),
    .table_select_i (sel_d),
    .key_first_i    (key_first_d),
    .key_second_i   (key_second_d),
    .entry_index_i  (index_d),
    .entry_code_i   (code_d),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .code_o         (code_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Hard stop in case the block hangs or stops producing codes.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d codes outstanding.", cycle_count,
               expected_codes.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_fault(input string what);
    faults++;
    if (faults <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, what);
    end
  endtask

  // Feeder: offers the pending items one after another and, at each acceptance, applies the
  // item to our copy of the tables. A lookup's expected code is worked out right there, so the
  // store of expected codes is always in acceptance order.
  always @(posedge clk_i or negedge rst_ni) begin : feed_ops
    int unsigned n, lo, hi, mid;
    logic [15:0] key;
    logic [7:0]  found;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_stall) begin
        stalled_cycles++;
      end
      if (in_valid && !in_stall) begin
        key = {cur_op.key_first, cur_op.key_second};
        ops_accepted++;
        if (cur_op.action == ACT_LOAD) begin
          stored_key[cur_op.sel][cur_op.index]  = key;
          stored_code[cur_op.sel][cur_op.index] = cur_op.code;
          loads_seen++;
        end else begin
          found = 8'h00;
          n = (table_count[cur_op.sel] > DEPTH) ? DEPTH : table_count[cur_op.sel];
          if (cur_op.sel == SEL_NORMAL && cur_op.key_second == 8'h00) begin
            // A single-character name never touches the table.
            found = cur_op.key_first & SINGLE_MASK;
          end else if (n != 0 && key >= stored_key[cur_op.sel][0] &&
                       key <= stored_key[cur_op.sel][n-1]) begin
            // Halve the window [lo, hi) until one entry is left, then compare exactly.
            // An unsorted table goes through the same steps and takes whatever is left.
            lo = 0;
            hi = n;
            while (lo + 1 != hi) begin
              mid = lo + (hi - lo) / 2;
              if (key < stored_key[cur_op.sel][mid]) begin
                hi = mid;
              end else begin
                lo = mid;
              end
            end
            if (key == stored_key[cur_op.sel][lo]) begin
              found = stored_code[cur_op.sel][lo];
            end
          end
          expected_codes.push_back('{found, cur_op.sel, key});
          lookups_seen++;
        end
        // Every so often a run of items goes back to back, otherwise a random gap follows.
        send_wait = ((ops_accepted % 96) < 24) ? 0 : $urandom_range(0, 3);
      end
      if (!in_valid || !in_stall) begin
        if (send_wait != 0) begin
          in_valid <= 1'b0;
          send_wait--;
        end else if (pending_ops.size() != 0) begin
          cur_op = pending_ops.pop_front();
          act_d        <= cur_op.action;
          sel_d        <= cur_op.sel;
          key_first_d  <= cur_op.key_first;
          key_second_d <= cur_op.key_second;
          index_d      <= cur_op.index;
          code_d       <= cur_op.code;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted code against the oldest expectation and then may stall at
  // random. Once, with plenty of items still queued, it holds off for a long stretch so
  // that the output register stays full and the block has to stall its input.
  always @(posedge clk_i or negedge rst_ni) begin : take_codes
    code_expect_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_codes.size() == 0) begin
          report_fault($sformatf("code %02h arrived with no lookup outstanding", code_out));
        end else begin
          want = expected_codes.pop_front();
          codes_checked++;
          if (code_out !== want.code) begin
            report_fault($sformatf("%s table, key %04h: expected code %02h, got %02h",
                                   want.sel ? "special" : "normal", want.key, want.code,
                                   code_out));
          end
        end
        recv_wait = ((results_seen % 80) < 20) ? 0 : $urandom_range(0, 3);
        if (!held_off && results_seen >= HOLD_AFTER && pending_ops.size() > 20) begin
          recv_wait = HOLD_CYCLES;
          held_off  = 1'b1;
        end
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait != 0);
    end
  end

  task automatic push_op(input logic action, input logic sel, input logic [15:0] key,
                         input logic [6:0] index, input logic [7:0] code);
    pending_ops.push_back('{action, sel, key[15:8], key[7:0], index, code});
    ops_issued++;
    if (action == ACT_LOAD) begin
      issued_key[sel][index] = key;
    end
  endtask

  // Index and code are don't-cares on a lookup, so they carry random bits.
  task automatic push_lookup(input logic sel, input logic [15:0] key);
    push_op(ACT_LOOKUP, sel, key, 7'($urandom), 8'($urandom));
  endtask

  // Waits until every item is accepted and every code has come back, then lets the block
  // finish any load it may still be writing.
  task automatic wait_idle();
    while (ops_accepted != ops_issued || expected_codes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Setup cycle then access cycle; the register takes the value at the access edge.
  // Bits above the count carry random data, which the block must ignore.
  task automatic write_reg(input logic index, input logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {24'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    table_count[index] = value;
  endtask

  task automatic set_counts(input logic [7:0] normal_n, input logic [7:0] special_n);
    wait_idle();
    write_reg(REG_NORMAL_COUNT, normal_n);
    write_reg(REG_SPECIAL_COUNT, special_n);
    settings_seen++;
  endtask

  // Loads all entries of one table with strictly rising keys and random codes. With
  // full_span the table starts at key 0000 and ends at FFFF, otherwise keys exist on both sides.
  task automatic fill_sorted(input logic sel, input bit full_span);
    logic [15:0] key;
    key = full_span ? 16'h0000 : 16'($urandom_range(1, 300));
    for (int i = 0; i < DEPTH; i++) begin
      if (full_span && i == DEPTH - 1) begin
        key = 16'hFFFF;
      end
      push_op(ACT_LOAD, sel, key, 7'(i), 8'($urandom));
      key = key + 16'($urandom_range(1, 500));
    end
  endtask

  // A random mix, mostly lookups, many aimed at keys the tables hold. Loads keep each entry's key
  // and only change its code, unless reorder is set, in which case they scramble the order.
  task automatic mixed_ops(input int count, input bit reorder);
    logic        sel;
    logic [15:0] key;
    logic [6:0]  index;
    int unsigned n, pick;
    for (int i = 0; i < count; i++) begin
      sel   = 1'($urandom);
      key   = 16'($urandom);
      index = 7'($urandom);
      n     = (table_count[sel] > DEPTH) ? DEPTH : table_count[sel];
      pick  = $urandom_range(0, 99);
      if (pick < 12) begin
        if (!reorder) begin
          key = issued_key[sel][index];
        end
        push_op(ACT_LOAD, sel, key, index, 8'($urandom));
      end else begin
        if (pick < 22) begin
          sel       = SEL_NORMAL;
          key[7:0]  = 8'h00;
        end else if (n == 0 || pick >= 90) begin
          // Leave the key fully random.
        end else if (pick < 56) begin
          key = issued_key[sel][$urandom_range(0, n - 1)];
        end else if (pick < 70) begin
          key = issued_key[sel][$urandom_range(0, n - 1)] +
                ($urandom_range(0, 1) ? 16'h0001 : 16'hFFFF);
        end else begin
          case ($urandom_range(0, 3))
            0: key = 16'h0000;
            1: key = 16'hFFFF;
            2: key = issued_key[sel][0] - 16'h0001;
            default: key = issued_key[sel][n - 1] + 16'h0001;
          endcase
        end
        push_lookup(sel, key);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Both counts are zero out of reset. A few entries go in first, but every table lookup here
    // must come back as zero because the tables count as empty. Single-character names on the
    // normal table return the first byte with its top bit cleared, whatever the count.
    push_op(ACT_LOAD, SEL_NORMAL,  16'h2001, 7'd0, 8'h11);
    push_op(ACT_LOAD, SEL_NORMAL,  16'h4001, 7'd1, 8'hFF);
    push_op(ACT_LOAD, SEL_NORMAL,  16'h8080, 7'd2, 8'h00);
    push_op(ACT_LOAD, SEL_SPECIAL, 16'h0000, 7'd0, 8'h80);
    push_op(ACT_LOAD, SEL_SPECIAL, 16'hFFFF, 7'd1, 8'h7F);
    push_lookup(SEL_NORMAL,  16'h4100);
    push_lookup(SEL_NORMAL,  16'h0000);
    push_lookup(SEL_NORMAL,  16'hFF00);
    push_lookup(SEL_NORMAL,  16'h8000);
    push_lookup(SEL_NORMAL,  16'h1234);
    push_lookup(SEL_SPECIAL, 16'h0000);
    push_lookup(SEL_SPECIAL, 16'hFFFF);
    push_lookup(SEL_SPECIAL, 16'h4100);

    // Small tables: hits on the first, middle and last entries, keys below the first and above
    // the last, a key that falls between two entries, and the special table's extreme keys.
    set_counts(8'd3, 8'd2);
    push_lookup(SEL_NORMAL,  16'h2001);
    push_lookup(SEL_NORMAL,  16'h4001);
    push_lookup(SEL_NORMAL,  16'h8080);
    push_lookup(SEL_NORMAL,  16'h1001);
    push_lookup(SEL_NORMAL,  16'h9001);
    push_lookup(SEL_NORMAL,  16'h3001);
    push_lookup(SEL_SPECIAL, 16'h0000);
    push_lookup(SEL_SPECIAL, 16'hFFFF);
    push_lookup(SEL_SPECIAL, 16'h8000);

    // Fill both tables completely so that any count from here on only reads written entries.
    fill_sorted(SEL_NORMAL, 1'b0);
    fill_sorted(SEL_SPECIAL, 1'b0);

    // A sweep of counts: full tables, one and two entries, counts past the depth (which act as
    // a full table) and an empty table on either side.
    set_counts(8'd128, 8'd128);
    mixed_ops(60, 1'b0);
    set_counts(8'd1, 8'd1);
    mixed_ops(35, 1'b0);
    set_counts(8'd2, 8'd5);
    mixed_ops(40, 1'b0);
    set_counts(8'd255, 8'd129);
    mixed_ops(50, 1'b0);
    set_counts(8'd0, 8'd7);
    mixed_ops(35, 1'b0);
    set_counts(8'd37, 8'd0);
    mixed_ops(35, 1'b0);

    // Reload the special table so that it runs from key 0000 to FFFF.
    fill_sorted(SEL_SPECIAL, 1'b1);
    set_counts(8'd128, 8'd255);
    mixed_ops(60, 1'b0);
    set_counts(8'd127, 8'd64);
    mixed_ops(50, 1'b0);
    set_counts(8'd90, 8'd128);
    mixed_ops(40, 1'b0);

    // Loads now write random keys, so the tables lose their order; the search must still end
    // and return whatever its final probe lands on.
    set_counts(8'd128, 8'd128);
    mixed_ops(60, 1'b1);
    set_counts(8'd16, 8'd100);
    mixed_ops(50, 1'b1);

    wait_idle();
    $display("Covered %0d loads and %0d lookups under %0d count settings, sorted and unsorted.",
             loads_seen, lookups_seen, settings_seen);
    $display("Checked %0d codes; the input was held off for %0d cycles; %0d faults.",
             codes_checked, stalled_cycles, faults);
    if (faults == 0 && expected_codes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
